[hdl/sparse_set_worklist_top_macros.svh]
// Assertion macros for the sparse set worklist block.
`ifndef SPARSE_SET_WORKLIST_TOP_MACROS_SVH
`define SPARSE_SET_WORKLIST_TOP_MACROS_SVH

`ifndef SYNTH
// Antecedent implies consequent in the same cycle.
`define SSWL_ASSERT_NOW(label, clk_s, rstn_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("sswl check failed");
// Antecedent implies consequent in the next cycle.
`define SSWL_ASSERT_NEXT(label, clk_s, rstn_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("sswl check failed");
`else
`define SSWL_ASSERT_NOW(label, clk_s, rstn_s, ante, cons)
`define SSWL_ASSERT_NEXT(label, clk_s, rstn_s, ante, cons)
`endif

`endif

[hdl/sswl_pkg.sv]
// Shared types and constants of the sparse set worklist block.
`default_nettype none
package sswl_pkg;

  localparam int unsigned ID_W        = 10;
  localparam int unsigned COUNT_W     = 11;
  localparam int unsigned ID_SPACE    = 1 << ID_W;
  localparam int unsigned MAX_IDS_DEF = 1024;

  // Request codes
  typedef enum logic [1:0] {
    REQ_ADD    = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_POP    = 2'd2,
    REQ_CLEAR  = 2'd3
  } req_type_t;

  typedef struct packed {
    req_type_t         req_type;
    logic [ID_W-1:0]   item_id;
  } in_item_t;

  typedef struct packed {
    logic [ID_W-1:0]    popped_id;
    logic               popped_valid;
    logic [COUNT_W-1:0] member_count;
    logic               set_empty;
  } out_item_t;

endpackage
`default_nettype wire

[hdl/sswl_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none
module sswl_ram #(
  parameter int unsigned WIDTH = 10,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; data holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

[hdl/sparse_set_worklist_top.sv]
// Sparse set worklist: index RAM plus packed id RAM with a lookup/commit sequencer.
//
//   channel  | ports                        | payload
//   ---------+------------------------------+--------------------------------
//   request  | in_valid, in_stall, in_item  | req_type, item_id
//   result   | out_valid, out_stall, out_item | popped_id, popped_valid,
//            |                              | member_count, set_empty
//
// Each request passes through accept (index read and last-entry read),
// lookup (packed-array read at the found position), then commit, which overlaps
// the next accept. The index read feeds the dependent packed-id read, so no new
// request is taken during lookup. The result register loads at commit. Reset clears
// the count, the sequencer and out_valid only; the RAMs need no clearing pass. A held
// result stalls the commit, which in turn stalls the request channel.
`default_nettype none
`include "sparse_set_worklist_top_macros.svh"
module sparse_set_worklist_top import sswl_pkg::*; #(
  parameter int unsigned MAX_IDS = MAX_IDS_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_item,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_item
);

  localparam int unsigned ID_DEPTH = (MAX_IDS < ID_SPACE) ? MAX_IDS : ID_SPACE;
  localparam int unsigned IW       = $clog2(ID_DEPTH);
  localparam int unsigned CW       = $clog2(ID_DEPTH + 1);
  localparam logic [ID_W:0]  ID_LIM    = (ID_W + 1)'(ID_DEPTH);
  localparam logic [CW-1:0]  COUNT_MAX = CW'(ID_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_LOOK   = 3'b010,
    S_COMMIT = 3'b100
  } state_t;

  state_t           state_r, state_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             out_valid_r;
  out_item_t        out_item_r;

  req_type_t        req_r;
  logic [ID_W-1:0]  id_r;
  logic             in_range_r;
  logic [IW-1:0]    pos_r;
  logic [ID_W-1:0]  last_r;
  logic             fwd_idx_r;
  logic [IW-1:0]    fwd_idx_data_r;
  logic             fwd_last_r;
  logic [ID_W-1:0]  fwd_last_data_r;

  logic             accept, commit_go, is_member;
  logic [CW-1:0]    last_addr;
  logic [IW-1:0]    pos_c;
  logic [ID_W-1:0]  last_c;
  logic [ID_W-1:0]  popped_id;
  logic             popped_valid;

  logic             idx_we, idx_re, dense_we, dense_re;
  logic [IW-1:0]    idx_waddr, idx_wdata, idx_raddr, idx_rdata;
  logic [IW-1:0]    dense_waddr, dense_raddr;
  logic [ID_W-1:0]  dense_wdata, dense_rdata;

  // Position of each id in the packed array
  sswl_ram #(.WIDTH(IW), .DEPTH(ID_DEPTH)) u_idx_ram (
    .clk   (clk),
    .we    (idx_we),
    .waddr (idx_waddr),
    .wdata (idx_wdata),
    .re    (idx_re),
    .raddr (idx_raddr),
    .rdata (idx_rdata)
  );

  // Packed array of member ids
  sswl_ram #(.WIDTH(ID_W), .DEPTH(ID_DEPTH)) u_dense_ram (
    .clk   (clk),
    .we    (dense_we),
    .waddr (dense_waddr),
    .wdata (dense_wdata),
    .re    (dense_re),
    .raddr (dense_raddr),
    .rdata (dense_rdata)
  );

  // Handshake
  assign commit_go = (state_r == S_COMMIT) && (!out_valid_r || !out_stall);
  assign in_stall  = !((state_r == S_IDLE) || commit_go);
  assign accept    = in_valid && !in_stall;

  // Read data, with forwarding of a commit that coincided with the accept
  assign pos_c  = fwd_idx_r  ? fwd_idx_data_r  : idx_rdata;
  assign last_c = fwd_last_r ? fwd_last_data_r : dense_rdata;

  // Membership: id in range, position below count and packed entry matches
  assign is_member = in_range_r && (CW'(pos_r) < count_r) && (dense_rdata == id_r);

  // Commit: RAM writes, new count, pop result
  always_comb begin
    count_nxt    = count_r;
    idx_we       = 1'b0;
    idx_waddr    = id_r[IW-1:0];
    idx_wdata    = count_r[IW-1:0];
    dense_we     = 1'b0;
    dense_waddr  = count_r[IW-1:0];
    dense_wdata  = id_r;
    popped_id    = '0;
    popped_valid = 1'b0;
    if (commit_go) begin
      case (req_r)
        REQ_ADD: begin
          if (in_range_r && !is_member && (count_r < COUNT_MAX)) begin
            idx_we    = 1'b1;
            dense_we  = 1'b1;
            count_nxt = count_r + CW'(1);
          end
        end
        REQ_REMOVE: begin
          if (is_member) begin
            // move last entry into the freed slot
            dense_we    = 1'b1;
            dense_waddr = pos_r;
            dense_wdata = last_r;
            idx_we      = 1'b1;
            idx_waddr   = last_r[IW-1:0];
            idx_wdata   = pos_r;
            count_nxt   = count_r - CW'(1);
          end
        end
        REQ_POP: begin
          if (count_r != '0) begin
            count_nxt    = count_r - CW'(1);
            popped_id    = last_r;
            popped_valid = 1'b1;
          end
        end
        REQ_CLEAR: begin
          count_nxt = '0;
        end
        default: begin
          count_nxt = count_r;
        end
      endcase
    end
  end

  // Read addressing: index and last entry at accept, packed entry at lookup
  assign last_addr   = count_nxt - CW'(1);
  assign idx_re      = accept;
  assign idx_raddr   = in_item.item_id[IW-1:0];
  assign dense_re    = accept || (state_r == S_LOOK);
  assign dense_raddr = (state_r == S_LOOK) ? pos_c : last_addr[IW-1:0];

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (accept) state_nxt = S_LOOK;
      S_LOOK:   state_nxt = S_COMMIT;
      S_COMMIT: if (commit_go) state_nxt = accept ? S_LOOK : S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (commit_go) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r           <= in_item.req_type;
      id_r            <= in_item.item_id;
      in_range_r      <= ({1'b0, in_item.item_id} < ID_LIM);
      fwd_idx_r       <= idx_we && (idx_waddr == in_item.item_id[IW-1:0]);
      fwd_idx_data_r  <= idx_wdata;
      fwd_last_r      <= dense_we && (dense_waddr == last_addr[IW-1:0]);
      fwd_last_data_r <= dense_wdata;
    end
    if (state_r == S_LOOK) begin
      pos_r  <= pos_c;
      last_r <= last_c;
    end
    if (commit_go) begin
      out_item_r.popped_id    <= popped_id;
      out_item_r.popped_valid <= popped_valid;
      out_item_r.member_count <= COUNT_W'(count_nxt);
      out_item_r.set_empty    <= (count_nxt == '0);
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Checks
  `SSWL_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_r <= COUNT_MAX)
  `SSWL_ASSERT_NOW(a_write_in_commit, clk, rst_n, idx_we || dense_we, state_r == S_COMMIT)
  `SSWL_ASSERT_NEXT(a_commit_loads_out, clk, rst_n, commit_go, out_valid_r)
  `SSWL_ASSERT_NOW(a_accept_state, clk, rst_n, accept,
                   (state_r == S_IDLE) || (state_r == S_COMMIT))

endmodule
`default_nettype wire
